### hdl/lls_pkg.sv
// Shared types and constants for the least-loaded selector.
// Used by lls_ctrl, lls_dp and least_loaded_selector_unit; no dependencies.
package lls_pkg;

  localparam int SLOTS_DEF   = 16;
  localparam int ID_BITS_DEF = 16;

  localparam int REQ_W    = 2;
  localparam int IN_ID_W  = 16;
  localparam int LOAD_W   = 16;
  localparam int STATUS_W = 3;
  localparam int OUT_ID_W = 16;
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 24;

  typedef enum logic [REQ_W-1:0] {
    REQ_ATTACH = 2'd0,
    REQ_DETACH = 2'd1,
    REQ_CHOOSE = 2'd2,
    REQ_UPDATE = 2'd3
  } req_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_ATTACHED  = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_FULL      = 3'd3,
    ST_NONE      = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT,
    S_AGE,
    S_AGE_DRAIN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic load_req;
    logic clr_trk;
    logic rd_en;
    logic rd_age;
    logic commit;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic scan_last;
    logic need_age;
    logic out_free;
  } sts_t;

endpackage

### hdl/lls_ctrl.sv
// Sequencer for the least-loaded selector: table scan, commit, age pass, result.
// Depends on lls_pkg.
module lls_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_tvalid,
  output logic           in_tready,
  input  lls_pkg::sts_t  sts,
  output lls_pkg::cmd_t  cmd
);

  lls_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lls_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      lls_pkg::S_IDLE: begin
        if (in_tvalid) state_nxt = lls_pkg::S_SCAN;
      end
      lls_pkg::S_SCAN: begin
        if (sts.scan_last) state_nxt = lls_pkg::S_DRAIN;
      end
      lls_pkg::S_DRAIN: begin
        state_nxt = lls_pkg::S_COMMIT;
      end
      lls_pkg::S_COMMIT: begin
        state_nxt = sts.need_age ? lls_pkg::S_AGE : lls_pkg::S_DONE;
      end
      lls_pkg::S_AGE: begin
        if (sts.scan_last) state_nxt = lls_pkg::S_AGE_DRAIN;
      end
      lls_pkg::S_AGE_DRAIN: begin
        state_nxt = lls_pkg::S_DONE;
      end
      lls_pkg::S_DONE: begin
        if (sts.out_free) state_nxt = lls_pkg::S_IDLE;
      end
      default: begin
        state_nxt = lls_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      lls_pkg::S_IDLE: begin
        in_tready    = 1'b1;
        cmd.load_req = in_tvalid;
        cmd.clr_trk  = in_tvalid;
      end
      lls_pkg::S_SCAN: begin
        cmd.rd_en = 1'b1;
      end
      lls_pkg::S_COMMIT: begin
        cmd.commit = 1'b1;
      end
      lls_pkg::S_AGE: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_age = 1'b1;
      end
      lls_pkg::S_DONE: begin
        cmd.out_load = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

### hdl/lls_dp.sv
// Datapath for the least-loaded selector: slot table, serial scan trackers,
// commit writes, age write-back and result register. Depends on lls_pkg.
module lls_dp #(
  parameter int SLOTS   = lls_pkg::SLOTS_DEF,
  parameter int ID_BITS = lls_pkg::ID_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  lls_pkg::cmd_t                 cmd,
  output lls_pkg::sts_t                 sts,
  input  logic [lls_pkg::REQ_W-1:0]     in_req_type,
  input  logic [lls_pkg::IN_ID_W-1:0]   in_worker_id,
  input  logic [lls_pkg::LOAD_W-1:0]    in_load_value,
  input  logic                          in_eligible_flag,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [lls_pkg::STATUS_W-1:0]  out_status,
  output logic [lls_pkg::OUT_ID_W-1:0]  out_chosen_id
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  // slot table
  logic [SLOTS-1:0]          valid_r;
  logic [ID_BITS-1:0]        mem_worker [SLOTS];
  logic [lls_pkg::LOAD_W-1:0] mem_load  [SLOTS];
  logic                      mem_elig   [SLOTS];
  logic [IDX_W-1:0]          mem_age    [SLOTS];
  logic [CNT_W-1:0]          cnt_r;

  // request
  lls_pkg::req_t             req_r;
  logic [ID_BITS-1:0]        id_r;
  logic [lls_pkg::LOAD_W-1:0] load_r;
  logic                      elig_r;

  // scan
  logic [IDX_W-1:0]          idx_r;
  logic                      chk_v_r, chk_age_r;
  logic [IDX_W-1:0]          chk_idx_r;
  logic [ID_BITS-1:0]        rd_worker_r;
  logic [lls_pkg::LOAD_W-1:0] rd_load_r;
  logic                      rd_elig_r;
  logic [IDX_W-1:0]          rd_age_r;

  // trackers
  logic                      found_r, free_r, best_r;
  logic [IDX_W-1:0]          found_idx_r, found_age_r, free_idx_r, best_age_r;
  logic [lls_pkg::LOAD_W-1:0] best_load_r;
  logic [ID_BITS-1:0]        best_id_r;

  // result
  logic                      out_v_r;
  lls_pkg::status_t          out_status_r, res_status;
  logic [lls_pkg::OUT_ID_W-1:0] out_chosen_r, res_chosen;

  // write port
  logic                      we;
  logic [IDX_W-1:0]          waddr;
  logic [ID_BITS-1:0]        w_worker;
  logic [lls_pkg::LOAD_W-1:0] w_load;
  logic                      w_elig;
  logic [IDX_W-1:0]          w_age;

  logic                      chk_present, chk_match, chk_better, age_dec;

  assign sts.scan_last = (idx_r == IDX_W'(SLOTS - 1));
  assign sts.need_age  = (req_r == lls_pkg::REQ_DETACH) && found_r;
  assign sts.out_free  = !out_v_r || out_tready;

  assign chk_present = chk_v_r && valid_r[chk_idx_r];
  assign chk_match   = chk_present && (rd_worker_r == id_r);
  assign chk_better  = chk_present && rd_elig_r &&
                       (!best_r || (rd_load_r < best_load_r) ||
                        ((rd_load_r == best_load_r) && (rd_age_r < best_age_r)));
  assign age_dec     = chk_present && chk_age_r && (rd_age_r > found_age_r);

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_r  <= lls_pkg::req_t'(in_req_type);
      id_r   <= ID_BITS'(in_worker_id);
      load_r <= in_load_value;
      elig_r <= in_eligible_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      chk_v_r   <= 1'b0;
      chk_age_r <= 1'b0;
    end else begin
      chk_v_r   <= cmd.rd_en;
      chk_age_r <= cmd.rd_age;
      if (cmd.clr_trk) begin
        idx_r <= '0;
      end else if (cmd.rd_en) begin
        idx_r <= sts.scan_last ? '0 : idx_r + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      chk_idx_r   <= idx_r;
      rd_worker_r <= mem_worker[idx_r];
      rd_load_r   <= mem_load[idx_r];
      rd_elig_r   <= mem_elig[idx_r];
      rd_age_r    <= mem_age[idx_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r <= 1'b0;
      free_r  <= 1'b0;
      best_r  <= 1'b0;
    end else if (cmd.clr_trk) begin
      found_r <= 1'b0;
      free_r  <= 1'b0;
      best_r  <= 1'b0;
    end else if (chk_v_r && !chk_age_r) begin
      if (!valid_r[chk_idx_r] && !free_r) begin
        free_r     <= 1'b1;
        free_idx_r <= chk_idx_r;
      end
      if (chk_match) begin
        found_r     <= 1'b1;
        found_idx_r <= chk_idx_r;
        found_age_r <= rd_age_r;
      end
      if (chk_better) begin
        best_r      <= 1'b1;
        best_load_r <= rd_load_r;
        best_age_r  <= rd_age_r;
        best_id_r   <= rd_worker_r;
      end
    end
  end

  always_comb begin
    we       = 1'b0;
    waddr    = chk_idx_r;
    w_worker = rd_worker_r;
    w_load   = rd_load_r;
    w_elig   = rd_elig_r;
    w_age    = rd_age_r - IDX_W'(1);
    if (cmd.commit) begin
      case (req_r)
        lls_pkg::REQ_ATTACH: begin
          we       = !found_r && free_r;
          waddr    = free_idx_r;
          w_worker = id_r;
          w_load   = '0;
          w_elig   = 1'b0;
          w_age    = IDX_W'(cnt_r);
        end
        lls_pkg::REQ_UPDATE: begin
          we       = found_r;
          waddr    = found_idx_r;
          w_worker = id_r;
          w_load   = load_r;
          w_elig   = elig_r;
          w_age    = found_age_r;
        end
        default: begin
          we = 1'b0;
        end
      endcase
    end else begin
      we = age_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem_worker[waddr] <= w_worker;
      mem_load[waddr]   <= w_load;
      mem_elig[waddr]   <= w_elig;
      mem_age[waddr]    <= w_age;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      cnt_r   <= '0;
    end else if (cmd.commit) begin
      if (req_r == lls_pkg::REQ_ATTACH && !found_r && free_r) begin
        valid_r[free_idx_r] <= 1'b1;
        cnt_r               <= cnt_r + CNT_W'(1);
      end else if (req_r == lls_pkg::REQ_DETACH && found_r) begin
        valid_r[found_idx_r] <= 1'b0;
        cnt_r                <= cnt_r - CNT_W'(1);
      end
    end
  end

  always_comb begin
    res_status = lls_pkg::ST_OK;
    res_chosen = '0;
    case (req_r)
      lls_pkg::REQ_ATTACH: begin
        if (found_r)     res_status = lls_pkg::ST_ATTACHED;
        else if (!free_r) res_status = lls_pkg::ST_FULL;
      end
      lls_pkg::REQ_CHOOSE: begin
        if (best_r) res_chosen = lls_pkg::OUT_ID_W'(best_id_r);
        else        res_status = lls_pkg::ST_NONE;
      end
      default: begin
        if (!found_r) res_status = lls_pkg::ST_NOT_FOUND;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= res_status;
      out_chosen_r <= res_chosen;
    end
  end

  assign out_tvalid    = out_v_r;
  assign out_status    = out_status_r;
  assign out_chosen_id = out_chosen_r;

endmodule

### hdl/least_loaded_selector_unit.sv
// Least-loaded selector: attach, detach, update and choose over a worker table.
// Each request is scanned serially over the table memory port, one slot per cycle,
// then committed; a detach that hits adds an age pass over the table. A new request
// is accepted only after the result of the previous one is loaded into the output
// register, which waits while a pending result has not yet been taken.
// Reset (synchronous, rst_n low) clears all valid bits and the entry count.
module least_loaded_selector_unit #(
  parameter int SLOTS   = lls_pkg::SLOTS_DEF,
  parameter int ID_BITS = lls_pkg::ID_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [lls_pkg::IN_DATA_W-1:0]    in_tdata,  // worker_id, load_value, eligible_flag
  input  logic [lls_pkg::REQ_W-1:0]        in_tuser,  // req_type
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [lls_pkg::OUT_DATA_W-1:0]   out_tdata  // status, chosen_id
);

  localparam int LD_LO = lls_pkg::IN_ID_W;
  localparam int EL_B  = LD_LO + lls_pkg::LOAD_W;
  localparam int CH_LO = lls_pkg::STATUS_W;
  localparam int PAD_W = lls_pkg::OUT_DATA_W - lls_pkg::STATUS_W - lls_pkg::OUT_ID_W;

  lls_pkg::cmd_t cmd;
  lls_pkg::sts_t sts;
  logic [lls_pkg::STATUS_W-1:0] out_status;
  logic [lls_pkg::OUT_ID_W-1:0] out_chosen_id;

  lls_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  lls_dp #(
    .SLOTS   (SLOTS),
    .ID_BITS (ID_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_req_type      (in_tuser),
    .in_worker_id     (in_tdata[LD_LO-1:0]),
    .in_load_value    (in_tdata[EL_B-1:LD_LO]),
    .in_eligible_flag (in_tdata[EL_B]),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_status       (out_status),
    .out_chosen_id    (out_chosen_id)
  );

  assign out_tdata = {{PAD_W{1'b0}}, out_chosen_id, out_status};

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("item accepted while previous item in progress");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> (!out_tvalid || out_tready))
    else $error("pending result overwritten");

  a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> !cmd.rd_en && !$past(cmd.rd_en))
    else $error("table commit overlaps scan");

  a_chosen_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[CH_LO-1:0] != lls_pkg::ST_OK) |-> out_chosen_id == '0)
    else $error("chosen id nonzero on failed request");

endmodule

### verif/least_loaded_selector_unit_tb.sv
// Self-checking testbench for least_loaded_selector_unit: attach, detach, update and choose
// requests against a worker-table predictor, with random gaps and a long output hold-off.
// Depends on lls_pkg and the least_loaded_selector_unit RTL only.
`timescale 1ns / 100ps

module least_loaded_selector_unit_tb;

  localparam int TABLE_SLOTS = lls_pkg::SLOTS_DEF;
  localparam int POOL_SIZE   = 24;
  localparam int IDLE_LIMIT  = 4000;
  localparam int SETTLE_CYC  = 2 * TABLE_SLOTS + 16;
  localparam int MAX_SHOWN   = 10;

  typedef struct {
    lls_pkg::status_t status;
    logic [15:0]      chosen_id;
  } reply_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_tvalid;
  logic                           in_tready;
  logic [lls_pkg::IN_DATA_W-1:0]  in_tdata;
  logic [lls_pkg::REQ_W-1:0]      in_tuser;
  logic                           out_tvalid;
  logic                           out_tready;
  logic [lls_pkg::OUT_DATA_W-1:0] out_tdata;

  bit          slot_used [TABLE_SLOTS];
  logic [15:0] slot_id   [TABLE_SLOTS];
  logic [15:0] slot_ld   [TABLE_SLOTS];
  bit          slot_el   [TABLE_SLOTS];
  int          slot_rank [TABLE_SLOTS];
  int          used_count;

  reply_t      replies_due[$];
  logic [15:0] id_pool[POOL_SIZE];
  int          mismatches;
  int          idle_cycles;
  int          hold_request;
  bit          sender_idles;
  bit          receiver_idles;

  least_loaded_selector_unit u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic void note_mismatch(string what);
    if (mismatches < MAX_SHOWN) $display("mismatch: %s", what);
    mismatches++;
  endfunction

  task automatic table_clear();
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      slot_used[i] = 1'b0;
      slot_ld[i]   = '0;
      slot_el[i]   = 1'b0;
      slot_rank[i] = 0;
    end
    used_count = 0;
  endtask

  task automatic table_apply(input lls_pkg::req_t req, input logic [15:0] id,
                             input logic [15:0] load, input logic elig,
                             output reply_t reply);
    int hit;
    int free_slot;
    int best;
    int gone;
    hit = -1;
    free_slot = -1;
    best = -1;
    reply.status = lls_pkg::ST_OK;
    reply.chosen_id = '0;
    for (int i = 0; i < TABLE_SLOTS; i++) begin
      if (hit < 0 && slot_used[i] && slot_id[i] == id) hit = i;
      if (free_slot < 0 && !slot_used[i]) free_slot = i;
    end
    case (req)
      lls_pkg::REQ_ATTACH: begin
        if (hit >= 0) begin
          reply.status = lls_pkg::ST_ATTACHED;
        end else if (free_slot < 0) begin
          reply.status = lls_pkg::ST_FULL;
        end else begin
          slot_used[free_slot] = 1'b1;
          slot_id[free_slot]   = id;
          slot_ld[free_slot]   = '0;
          slot_el[free_slot]   = 1'b0;
          slot_rank[free_slot] = used_count;
          used_count++;
        end
      end
      lls_pkg::REQ_DETACH: begin
        if (hit < 0) begin
          reply.status = lls_pkg::ST_NOT_FOUND;
        end else begin
          gone = slot_rank[hit];
          slot_used[hit] = 1'b0;
          for (int i = 0; i < TABLE_SLOTS; i++)
            if (slot_used[i] && slot_rank[i] > gone) slot_rank[i]--;
          if (used_count > 0) used_count--;
        end
      end
      lls_pkg::REQ_CHOOSE: begin
        for (int i = 0; i < TABLE_SLOTS; i++) begin
          if (slot_used[i] && slot_el[i]) begin
            if (best < 0 || slot_ld[i] < slot_ld[best] ||
                (slot_ld[i] == slot_ld[best] && slot_rank[i] < slot_rank[best]))
              best = i;
          end
        end
        if (best < 0) reply.status = lls_pkg::ST_NONE;
        else reply.chosen_id = slot_id[best];
      end
      default: begin
        if (hit < 0) begin
          reply.status = lls_pkg::ST_NOT_FOUND;
        end else begin
          slot_ld[hit] = load;
          slot_el[hit] = elig;
        end
      end
    endcase
  endtask

  task automatic send_request(input lls_pkg::req_t req, input logic [15:0] id,
                              input logic [15:0] load, input logic elig);
    int gap;
    reply_t reply;
    gap = sender_idles ? pick_gap() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= req;
    in_tdata  <= {{(lls_pkg::IN_DATA_W - 33){1'b0}}, elig, load, id};
    do @(posedge clk); while (!in_tready);
    table_apply(req, id, load, elig, reply);
    replies_due.push_back(reply);
  endtask

  // result checker
  always @(posedge clk) begin : check_replies
    reply_t due;
    if (rst_n && out_tvalid && out_tready) begin
      if (replies_due.size() == 0) begin
        note_mismatch($sformatf("unexpected item status=%0d chosen=%h",
                                out_tdata[2:0], out_tdata[18:3]));
      end else begin
        due = replies_due.pop_front();
        if (out_tdata[2:0] !== due.status || out_tdata[18:3] !== due.chosen_id)
          note_mismatch($sformatf("expected status=%0d chosen=%h, got status=%0d chosen=%h",
                                  due.status, due.chosen_id, out_tdata[2:0], out_tdata[18:3]));
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // receiver: random stalls, plus a long hold-off on request
  initial begin : receiver
    int n;
    forever begin
      if (hold_request > 0) begin
        n = hold_request;
        hold_request = 0;
      end else begin
        n = receiver_idles ? pick_gap() : 0;
      end
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic test_empty_table();
    send_request(lls_pkg::REQ_CHOOSE, 16'h0000, 16'h0000, 1'b1);
    send_request(lls_pkg::REQ_DETACH, 16'h1234, 16'h0000, 1'b0);
    send_request(lls_pkg::REQ_UPDATE, 16'h1234, 16'h0007, 1'b1);
  endtask

  task automatic test_duplicate_attach();
    send_request(lls_pkg::REQ_ATTACH, 16'h0000, 16'hFFFF, 1'b1);
    send_request(lls_pkg::REQ_ATTACH, 16'h0000, 16'h0000, 1'b0);
    send_request(lls_pkg::REQ_CHOOSE, 16'h0000, 16'h0000, 1'b0);
    send_request(lls_pkg::REQ_ATTACH, 16'hFFFF, 16'h0000, 1'b0);
    send_request(lls_pkg::REQ_ATTACH, 16'h8001, 16'h0000, 1'b0);
  endtask

  task automatic test_least_load_and_ties();
    send_request(lls_pkg::REQ_UPDATE, 16'hFFFF, 16'hFFFF, 1'b1);
    send_request(lls_pkg::REQ_CHOOSE, 16'h0000, 16'h0000, 1'b0);
    send_request(lls_pkg::REQ_UPDATE, 16'h0000, 16'h0005, 1'b1);
    send_request(lls_pkg::REQ_UPDATE, 16'h8001, 16'h0005, 1'b1);
    send_request(lls_pkg::REQ_CHOOSE, 16'h0000, 16'h0000, 1'b0);
    send_request(lls_pkg::REQ_DETACH, 16'h0000, 16'h0000, 1'b0);
    send_request(lls_pkg::REQ_ATTACH, 16'h0000, 16'h0000, 1'b0);
    send_request(lls_pkg::REQ_UPDATE, 16'h0000, 16'h0005, 1'b1);
    send_request(lls_pkg::REQ_CHOOSE, 16'h0000, 16'h0000, 1'b0);
    send_request(lls_pkg::REQ_UPDATE, 16'h8001, 16'h0000, 1'b0);
    send_request(lls_pkg::REQ_CHOOSE, 16'h0000, 16'h0000, 1'b0);
    send_request(lls_pkg::REQ_UPDATE, 16'h0000, 16'hFFFF, 1'b1);
    send_request(lls_pkg::REQ_CHOOSE, 16'h0000, 16'h0000, 1'b0);
    send_request(lls_pkg::REQ_DETACH, 16'hFFFF, 16'h0000, 1'b0);
    send_request(lls_pkg::REQ_CHOOSE, 16'h0000, 16'h0000, 1'b0);
  endtask

  task automatic test_random_traffic(input int count, input int attach_w, input int detach_w,
                                     input int update_w);
    int roll;
    lls_pkg::req_t req;
    logic [15:0] id;
    logic [15:0] load;
    for (int k = 0; k < count; k++) begin
      roll = $urandom_range(0, 99);
      if (roll < attach_w) req = lls_pkg::REQ_ATTACH;
      else if (roll < attach_w + detach_w) req = lls_pkg::REQ_DETACH;
      else if (roll < attach_w + detach_w + update_w) req = lls_pkg::REQ_UPDATE;
      else req = lls_pkg::REQ_CHOOSE;
      if ($urandom_range(0, 9) == 0) id = $urandom();
      else id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
      roll = $urandom_range(0, 9);
      if (roll < 5) load = $urandom_range(0, 3);
      else if (roll < 9) load = $urandom();
      else load = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      send_request(req, id, load, $urandom_range(0, 1));
    end
  endtask

  task automatic test_input_backpressure();
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    hold_request = 300;
    test_random_traffic(24, 25, 20, 25);
  endtask

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= lls_pkg::REQ_ATTACH;
    mismatches = 0;
    hold_request = 0;
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    table_clear();
    id_pool[0] = 16'h0000;
    id_pool[1] = 16'hFFFF;
    for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = $urandom();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_table();
    test_duplicate_attach();
    test_least_load_and_ties();
    test_random_traffic(300, 40, 15, 25);
    test_random_traffic(200, 15, 40, 25);
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    test_random_traffic(250, 30, 20, 30);
    test_input_backpressure();
    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    test_random_traffic(150, 35, 15, 20);

    in_tvalid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
